/* design/mte_pkg.sv */
`default_nettype none

package mte_pkg;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_PUSH   = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_PEEK   = 2'd3;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
    } entry_t;

    typedef struct packed {
        logic   en;
        entry_t data;
    } ram_wr_t;

endpackage

`default_nettype wire

/* design/mte_slot_ram.sv */
`default_nettype none

module mte_slot_ram
    import mte_pkg::*;
#(
    parameter int DEPTH = 10,
    parameter int IDX_W = 4
)
(
    input  wire logic             clk,
    input  wire ram_wr_t          wr,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire logic [IDX_W-1:0] rd_idx,
    output entry_t                rd_data
);

    entry_t mem_reg [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr_idx] <= wr.data;
        end
        rd_data_reg <= mem_reg[rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/mru_endpoint_table.sv */
// Ordered table of peer endpoints (IPv4 address and UDP port), no duplicates; push moves to front.
// Input channel: in_valid / in_stall with kind, peer_addr, peer_port; a transaction
// is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with the head entry, entry count and the
// was_present, refused and tail_dropped flags; one result per input transaction.
// Entries sit in a one-port-write, one-port-read RAM with a registered read port.
// Append, push and remove first scan the list one entry a cycle, then move entries
// one a cycle to close or open a gap, then append and push write the new entry.
// The result is registered once this is done; a peek goes straight to its result.
// One transaction is in flight at a time; in_stall is high from acceptance until its
// result is registered, so the next transaction is taken only after that.
// The result register lets the next transaction be taken while a result waits.
// A stalled result holds; a finished transaction waits until the register frees.
// Reset empties the list at once; RAM contents are not cleared and are only read
// after being written.
`default_nettype none

module mru_endpoint_table
    import mte_pkg::*;
#(
    parameter int TABLE_DEPTH = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] peer_addr,
    input  wire logic [15:0] peer_port,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             head_valid,
    output logic [31:0]      head_addr,
    output logic [15:0]      head_port,
    output logic [3:0]       entry_total,
    output logic             was_present,
    output logic             refused,
    output logic             tail_dropped
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [1:0]       op_kind_reg, op_kind_next;
    entry_t           key_reg, key_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             up_reg, up_next;
    logic             wr_new_reg, wr_new_next;
    logic [IDX_W-1:0] wpos_reg, wpos_next;
    logic             present_reg, present_next;
    logic             refused_reg, refused_next;
    logic             dropped_reg, dropped_next;
    entry_t           head_reg, head_next;

    logic             out_valid_reg, out_valid_next;
    logic             res_head_valid_reg, res_head_valid_next;
    entry_t           res_head_reg, res_head_next;
    logic [3:0]       res_cnt_reg, res_cnt_next;
    logic             res_present_reg, res_present_next;
    logic             res_refused_reg, res_refused_next;
    logic             res_dropped_reg, res_dropped_next;

    ram_wr_t          ram_wr;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_data;

    logic             hit;
    logic             found;
    logic [CNT_W-1:0] fill_dec;
    logic [CNT_W+3:0] fill_wide;

    logic             set_up;
    logic [CNT_W-1:0] set_src;
    logic [CNT_W-1:0] set_left;
    logic [CNT_W-1:0] set_cnt;
    logic             set_wr_new;
    logic [IDX_W-1:0] set_wpos;
    logic             set_refused;
    logic             set_dropped;

    mte_slot_ram #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .wr_idx  (wr_idx),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    assign hit       = (rd_data == key_reg);
    assign found     = pend_reg && hit;
    assign fill_dec  = fill_reg - 1'b1;
    assign fill_wide = {4'b0000, fill_reg};

    always_comb
    begin
        set_up      = 1'b0;
        set_src     = pend_idx_reg + 1'b1;
        set_left    = '0;
        set_cnt     = fill_reg;
        set_wr_new  = 1'b0;
        set_wpos    = '0;
        set_refused = 1'b0;
        set_dropped = 1'b0;
        case (op_kind_reg)
            KIND_APPEND:
            begin
                if (found)
                begin
                    set_left   = fill_dec - pend_idx_reg;
                    set_wr_new = 1'b1;
                    set_wpos   = fill_dec[IDX_W-1:0];
                end
                else if (fill_reg >= DEPTH_C)
                begin
                    set_refused = 1'b1;
                end
                else
                begin
                    set_wr_new = 1'b1;
                    set_wpos   = fill_reg[IDX_W-1:0];
                    set_cnt    = fill_reg + 1'b1;
                end
            end
            KIND_PUSH:
            begin
                set_up     = 1'b1;
                set_wr_new = 1'b1;
                if (found)
                begin
                    set_src  = pend_idx_reg - 1'b1;
                    set_left = pend_idx_reg;
                end
                else if (fill_reg >= DEPTH_C)
                begin
                    set_dropped = 1'b1;
                    set_src     = DEPTH_C - 2'd2;
                    set_left    = DEPTH_C - 1'b1;
                    set_cnt     = DEPTH_C;
                end
                else
                begin
                    set_src  = fill_dec;
                    set_left = fill_reg;
                    set_cnt  = fill_reg + 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (found)
                begin
                    set_left = fill_dec - pend_idx_reg;
                    set_cnt  = fill_dec;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next          = state_reg;
        fill_next           = fill_reg;
        op_kind_next        = op_kind_reg;
        key_next            = key_reg;
        ptr_next            = ptr_reg;
        pend_next           = pend_reg;
        pend_idx_next       = pend_idx_reg;
        left_next           = left_reg;
        up_next             = up_reg;
        wr_new_next         = wr_new_reg;
        wpos_next           = wpos_reg;
        present_next        = present_reg;
        refused_next        = refused_reg;
        dropped_next        = dropped_reg;
        out_valid_next      = out_valid_reg && out_stall;
        res_head_valid_next = res_head_valid_reg;
        res_head_next       = res_head_reg;
        res_cnt_next        = res_cnt_reg;
        res_present_next    = res_present_reg;
        res_refused_next    = res_refused_reg;
        res_dropped_next    = res_dropped_reg;
        ram_wr              = '0;
        wr_idx              = '0;
        rd_idx              = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_kind_next = kind;
                    key_next     = '{addr: peer_addr, port: peer_port};
                    ptr_next     = '0;
                    pend_next    = 1'b0;
                    present_next = 1'b0;
                    refused_next = 1'b0;
                    dropped_next = 1'b0;
                    state_next   = (kind == KIND_PEEK) ? S_DONE : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (found || (!pend_reg && (ptr_reg >= fill_reg)))
                begin
                    state_next   = S_SHIFT;
                    pend_next    = 1'b0;
                    ptr_next     = set_src;
                    left_next    = set_left;
                    up_next      = set_up;
                    wr_new_next  = set_wr_new;
                    wpos_next    = set_wpos;
                    fill_next    = set_cnt;
                    present_next = found;
                    refused_next = set_refused;
                    dropped_next = set_dropped;
                end
                else if (ptr_reg < fill_reg)
                begin
                    rd_idx        = ptr_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg;
                    ptr_next      = ptr_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_wr.en   = 1'b1;
                    ram_wr.data = rd_data;
                    wr_idx      = pend_idx_reg[IDX_W-1:0];
                end
                if (left_reg != '0)
                begin
                    rd_idx        = ptr_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = up_reg ? ptr_reg + 1'b1 : ptr_reg - 1'b1;
                    ptr_next      = up_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                    left_next     = left_reg - 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (wr_new_reg)
                        begin
                            ram_wr.en   = 1'b1;
                            ram_wr.data = key_reg;
                            wr_idx      = wpos_reg;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    res_head_valid_next = (fill_reg != '0);
                    res_head_next       = (fill_reg != '0) ? head_reg : '0;
                    res_cnt_next        = fill_wide[3:0];
                    res_present_next    = present_reg;
                    res_refused_next    = refused_reg;
                    res_dropped_next    = dropped_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        head_next = head_reg;
        if (ram_wr.en && (wr_idx == '0))
        begin
            head_next = ram_wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_kind_reg        <= op_kind_next;
        key_reg            <= key_next;
        ptr_reg            <= ptr_next;
        pend_idx_reg       <= pend_idx_next;
        up_reg             <= up_next;
        wr_new_reg         <= wr_new_next;
        wpos_reg           <= wpos_next;
        present_reg        <= present_next;
        refused_reg        <= refused_next;
        dropped_reg        <= dropped_next;
        head_reg           <= head_next;
        res_head_valid_reg <= res_head_valid_next;
        res_head_reg       <= res_head_next;
        res_cnt_reg        <= res_cnt_next;
        res_present_reg    <= res_present_next;
        res_refused_reg    <= res_refused_next;
        res_dropped_reg    <= res_dropped_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign head_valid   = res_head_valid_reg;
    assign head_addr    = res_head_reg.addr;
    assign head_port    = res_head_reg.port;
    assign entry_total  = res_cnt_reg;
    assign was_present  = res_present_reg;
    assign refused      = res_refused_reg;
    assign tail_dropped = res_dropped_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("entry count exceeds table depth");

    a_wr_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr.en |-> (state_reg == S_SHIFT))
        else $error("RAM write outside move phase");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && pend_reg && left_reg != '0) |-> (pend_idx_reg != ptr_reg))
        else $error("move reads the entry being written");

    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_refused_reg && res_dropped_reg))
        else $error("refused and tail_dropped both set");

    a_peek_static: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && kind == KIND_PEEK) |=> (fill_reg == $past(fill_reg)))
        else $error("peek changed the entry count");
`endif

endmodule

`default_nettype wire

/* dv/mru_endpoint_table_checker.sv */
`timescale 1ns / 100ps

module mru_endpoint_table_checker
    import mte_pkg::*;
#(
    parameter int TABLE_DEPTH = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] peer_addr,
    input  wire logic [15:0] peer_port,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        head_valid,
    input  wire logic [31:0] head_addr,
    input  wire logic [15:0] head_port,
    input  wire logic [3:0]  entry_total,
    input  wire logic        was_present,
    input  wire logic        refused,
    input  wire logic        tail_dropped,
    output int               fail_count,
    output int               pending,
    output int               requests_seen,
    output int               responses_seen,
    output int               hit_count,
    output int               refuse_count,
    output int               drop_count,
    output int               full_count
);

    typedef struct packed {
        logic        head_valid;
        entry_t      head;
        logic [3:0]  total;
        logic        present;
        logic        refused;
        logic        dropped;
    } table_view_t;

    entry_t      roster[$];
    table_view_t expected_views[$];

    initial
    begin
        fail_count     = 0;
        pending        = 0;
        requests_seen  = 0;
        responses_seen = 0;
        hit_count      = 0;
        refuse_count   = 0;
        drop_count     = 0;
        full_count     = 0;
    end

    task automatic apply_request(input logic [1:0] op, input entry_t ep);
        table_view_t view;
        int          where;
        int          i;
        view  = '0;
        where = -1;
        if (op != KIND_PEEK)
        begin
            for (i = 0; i < roster.size(); i++)
            begin
                if (where < 0 && roster[i] == ep)
                    where = i;
            end
        end
        if (where >= 0)
        begin
            roster.delete(where);
            view.present = 1'b1;
            hit_count++;
        end
        case (op)
            KIND_APPEND:
            begin
                if (roster.size() >= TABLE_DEPTH)
                begin
                    view.refused = 1'b1;
                    refuse_count++;
                end
                else
                    roster.push_back(ep);
            end
            KIND_PUSH:
            begin
                if (roster.size() >= TABLE_DEPTH)
                begin
                    void'(roster.pop_back());
                    view.dropped = 1'b1;
                    drop_count++;
                end
                roster.push_front(ep);
            end
            KIND_REMOVE, KIND_PEEK:
            begin
            end
            default:
            begin
            end
        endcase
        if (roster.size() >= TABLE_DEPTH)
            full_count++;
        view.head_valid = (roster.size() > 0);
        view.head       = (roster.size() > 0) ? roster[0] : '0;
        view.total      = 4'(roster.size());
        expected_views.push_back(view);
        requests_seen++;
    endtask

    task automatic check_response();
        table_view_t want;
        if (expected_views.size() == 0)
        begin
            $error("result transaction with no request outstanding");
            fail_count++;
        end
        else
        begin
            want = expected_views.pop_front();
            responses_seen++;
            if (head_valid !== want.head_valid)
            begin
                $error("head_valid: expected %0d, got %0d", want.head_valid, head_valid);
                fail_count++;
            end
            if (head_addr !== want.head.addr)
            begin
                $error("head_addr: expected %h, got %h", want.head.addr, head_addr);
                fail_count++;
            end
            if (head_port !== want.head.port)
            begin
                $error("head_port: expected %h, got %h", want.head.port, head_port);
                fail_count++;
            end
            if (entry_total !== want.total)
            begin
                $error("entry_total: expected %0d, got %0d", want.total, entry_total);
                fail_count++;
            end
            if (was_present !== want.present)
            begin
                $error("was_present: expected %0d, got %0d", want.present, was_present);
                fail_count++;
            end
            if (refused !== want.refused)
            begin
                $error("refused: expected %0d, got %0d", want.refused, refused);
                fail_count++;
            end
            if (tail_dropped !== want.dropped)
            begin
                $error("tail_dropped: expected %0d, got %0d", want.dropped, tail_dropped);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roster.delete();
            expected_views.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_response();
            if (in_valid && !in_stall)
                apply_request(kind, {peer_addr, peer_port});
            pending = expected_views.size();
        end
    end

endmodule

/* dv/mru_endpoint_table_test.sv */
`timescale 1ns / 100ps

module mru_endpoint_table_test;
    import mte_pkg::*;

    localparam int TABLE_DEPTH    = 10;
    localparam int RANDOM_ITEMS   = 800;
    localparam int PHASE_LEN      = 40;
    localparam int POOL_SIZE      = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic        out_valid;
    logic        out_stall;
    logic        head_valid;
    logic [31:0] head_addr;
    logic [15:0] head_port;
    logic [3:0]  entry_total;
    logic        was_present;
    logic        refused;
    logic        tail_dropped;

    int fail_count;
    int pending;
    int requests_seen;
    int responses_seen;
    int hit_count;
    int refuse_count;
    int drop_count;
    int full_count;

    bit     calm;
    int     idle_cycles;
    entry_t pool[POOL_SIZE];

    mru_endpoint_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .peer_addr(peer_addr),
        .peer_port(peer_port),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .head_valid(head_valid),
        .head_addr(head_addr),
        .head_port(head_port),
        .entry_total(entry_total),
        .was_present(was_present),
        .refused(refused),
        .tail_dropped(tail_dropped)
    );

    mru_endpoint_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .peer_addr(peer_addr),
        .peer_port(peer_port),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .head_valid(head_valid),
        .head_addr(head_addr),
        .head_port(head_port),
        .entry_total(entry_total),
        .was_present(was_present),
        .refused(refused),
        .tail_dropped(tail_dropped),
        .fail_count(fail_count),
        .pending(pending),
        .requests_seen(requests_seen),
        .responses_seen(responses_seen),
        .hit_count(hit_count),
        .refuse_count(refuse_count),
        .drop_count(drop_count),
        .full_count(full_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [1:0] pick_kind(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                return (r < 45) ? KIND_APPEND : (r < 85) ? KIND_PUSH :
                       (r < 95) ? KIND_REMOVE : KIND_PEEK;
            MODE_DRAIN:
                return (r < 15) ? KIND_APPEND : (r < 30) ? KIND_PUSH :
                       (r < 90) ? KIND_REMOVE : KIND_PEEK;
            default:
                return (r < 30) ? KIND_APPEND : (r < 60) ? KIND_PUSH :
                       (r < 85) ? KIND_REMOVE : KIND_PEEK;
        endcase
    endfunction

    function automatic entry_t pick_endpoint();
        entry_t ep;
        if ($urandom_range(0, 3) == 0)
        begin
            ep.addr = $urandom;
            ep.port = 16'($urandom);
        end
        else
            ep = pool[$urandom_range(0, POOL_SIZE - 1)];
        return ep;
    endfunction

    task automatic refresh_pool(input int count);
        int i;
        int slot;
        for (i = 0; i < count; i++)
        begin
            slot = $urandom_range(0, POOL_SIZE - 1);
            pool[slot].port = 16'($urandom);
            if ($urandom_range(0, 3) == 0)
                pool[slot].addr = pool[(slot + 1) % POOL_SIZE].addr;
            else
                pool[slot].addr = $urandom;
        end
    endtask

    task automatic send(input logic [1:0] op, input logic [31:0] addr, input logic [15:0] port);
        int gap;
        gap = calm ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= op;
        peer_addr <= addr;
        peer_port <= port;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    initial
    begin
        int hold;
        out_stall = 1'b0;
        hold      = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 3) == 0)
                    hold = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** mru_endpoint_table: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int     i;
        int     mode;
        int     sent;
        entry_t ep;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_PEEK;
        peer_addr   = '0;
        peer_port   = '0;
        calm        = 1'b0;
        idle_cycles = 0;
        pool[0] = '{addr: 32'hFFFF_FFFF, port: 16'hFFFF};
        pool[1] = '{addr: 32'h0000_0000, port: 16'h0000};
        pool[2] = '{addr: 32'hFFFF_FFFF, port: 16'h0000};
        pool[3] = '{addr: 32'h0000_0000, port: 16'hFFFF};
        for (i = 4; i < POOL_SIZE; i++)
        begin
            pool[i].addr = $urandom;
            pool[i].port = 16'($urandom);
        end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(KIND_PEEK,   32'h0000_0000, 16'h0000);
        send(KIND_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        send(KIND_APPEND, 32'hFFFF_FFFF, 16'hFFFF);
        send(KIND_APPEND, 32'h0000_0000, 16'h0000);
        send(KIND_PUSH,   32'hC0A8_0001, 16'h0045);
        send(KIND_PUSH,   32'hFFFF_FFFF, 16'hFFFF);
        send(KIND_APPEND, 32'hC0A8_0001, 16'h0045);
        send(KIND_REMOVE, 32'h0000_0000, 16'h0000);
        send(KIND_REMOVE, 32'hC0A8_0001, 16'h0046);
        for (i = 0; i < TABLE_DEPTH - 2; i++)
            send(KIND_APPEND, 32'h0A00_0000 + i, 16'(1000 + i));
        send(KIND_APPEND, 32'h0B00_0001, 16'h1234);
        send(KIND_APPEND, 32'hFFFF_FFFF, 16'hFFFF);
        send(KIND_PUSH,   32'h0B00_0002, 16'h4321);
        send(KIND_PUSH,   32'h0A00_0003, 16'(1003));
        send(KIND_PEEK,   32'h5555_5555, 16'hAAAA);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode = $urandom_range(MODE_FILL, MODE_MIXED);
            calm = ($urandom_range(0, 4) == 0);
            refresh_pool(3);
            for (i = 0; i < PHASE_LEN && sent < RANDOM_ITEMS; i++)
            begin
                ep = pick_endpoint();
                send(pick_kind(mode), ep.addr, ep.port);
                sent++;
            end
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d requests and checked %0d results: %0d matches, %0d refused appends,",
                 requests_seen, responses_seen, hit_count, refuse_count);
        $display("%0d evicted tails, %0d operations leaving the table full.",
                 drop_count, full_count);
        if (fail_count == 0 && pending == 0)
            $display("** mru_endpoint_table: PASSED **");
        else
            $display("** mru_endpoint_table: FAILED **");
        $finish;
    end

endmodule
